### hw/rtl/sstf_pkg.sv
// Shared types and constants for the shortest-seek-time-first disk scheduler.
// No dependencies.
`default_nettype none
package sstf_pkg;
   localparam int PORT_TRACK_BITS = 12;
   localparam int MOVE_BITS = 18;
   localparam logic [MOVE_BITS-1:0] MOVE_MAX = 18'h3FFFF;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // Control shared by every cell of the ring.
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;
endpackage
`default_nettype wire

### hw/rtl/sstf_cell.sv
// One storage cell of the request ring: a track and its pending flag.
// Depends on sstf_pkg for the ring control struct.
`default_nettype none
module sstf_cell #(
   parameter int TRACK_BITS = 12
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire sstf_pkg::cell_ctrl_type ctrl,
   input  wire                       load_en,
   input  wire  [TRACK_BITS-1:0]     load_track,
   input  wire  [TRACK_BITS-1:0]     in_track,
   input  wire                       in_valid,
   output logic [TRACK_BITS-1:0]     track_out,
   output logic                      valid_out
);
   logic [TRACK_BITS-1:0] track_ff, track_in;
   logic                  valid_ff, valid_in;

   always_comb begin
      track_in = track_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         track_in = in_track;
         valid_in = in_valid;
      end else if (load_en) begin
         track_in = load_track;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      track_ff <= track_in;
   end

   assign track_out = track_ff;
   assign valid_out = valid_ff;
endmodule
`default_nettype wire

### hw/rtl/sstf_disk_scheduler_unit.sv
// Top level of the shortest-seek-time-first disk scheduler.
// Depends on sstf_pkg and sstf_cell.
`default_nettype none
// Load beats (op 0) store one request track each in the next free cell of a
// ring of MAX_REQUESTS cells; loads beyond a full store are dropped. A run
// beat (op 1) gives the starting head position and serves every stored
// request, nearest first, lower track first on equal distance, one result
// beat per request with the running movement total (saturating) and a last
// flag on the final one. To find each nearest request the ring rotates once
// past a single comparator at cell 0 during the scan state; the emit state
// then sends the result, waiting while the result output is stalled. The
// request side stalls for the whole run; a run with no stored requests emits
// nothing. The store is empty again after every run.
module sstf_disk_scheduler_unit #(
   parameter int MAX_REQUESTS = 64,
   parameter int TRACK_BITS   = 12
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_op,
   input  wire  [11:0] req_track,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [11:0] rsp_served_track,
   output logic [17:0] rsp_total_movement,
   output logic        rsp_last
);
   localparam int CW = $clog2(MAX_REQUESTS + 1);
   localparam int PW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int MB = sstf_pkg::MOVE_BITS;

   sstf_pkg::state_type state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         remain_ff, remain_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [PW-1:0]         best_pos_ff, best_pos_in;
   logic [PW-1:0]         kill_pos_ff, kill_pos_in;
   logic                  kill_en_ff, kill_en_in;
   logic                  found_ff, found_in;
   logic [TRACK_BITS-1:0] best_trk_ff, best_trk_in;
   logic [TRACK_BITS-1:0] best_dist_ff, best_dist_in;
   logic [TRACK_BITS-1:0] head_ff, head_in;
   logic [MB-1:0]         sum_ff, sum_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [11:0]           rsp_trk_ff, rsp_trk_in;
   logic [MB-1:0]         rsp_mov_ff, rsp_mov_in;
   logic                  rsp_last_ff, rsp_last_in;

   sstf_pkg::cell_ctrl_type ctrl;
   logic [TRACK_BITS-1:0] cell_trk [MAX_REQUESTS];
   logic                  cell_vld [MAX_REQUESTS];
   logic [TRACK_BITS-1:0] in_trk;
   logic                  wrap_vld;
   logic                  accept, do_load;
   logic [TRACK_BITS-1:0] seek_dist;
   logic [MB:0]           sum_wide;
   logic                  out_free;

   assign in_trk = TRACK_BITS'(req_track);
   assign accept = req_valid && !req_stall;
   assign do_load = accept && (req_op == sstf_pkg::OP_LOAD) &&
                    (count_ff < CW'(MAX_REQUESTS));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // The request served in the previous pass is dropped as it wraps around.
   assign wrap_vld = cell_vld[0] && !(kill_en_ff && pos_ff == kill_pos_ff);

   genvar g;
   generate
      for (g = 0; g < MAX_REQUESTS; g++) begin : g_cell
         logic [TRACK_BITS-1:0] nxt_trk;
         logic                  nxt_vld;
         if (g == MAX_REQUESTS - 1) begin : g_wrap
            assign nxt_trk = cell_trk[0];
            assign nxt_vld = wrap_vld;
         end else begin : g_mid
            assign nxt_trk = cell_trk[g+1];
            assign nxt_vld = cell_vld[g+1];
         end
         sstf_cell #(.TRACK_BITS(TRACK_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .load_en    (do_load && count_ff == CW'(g)),
            .load_track (in_trk),
            .in_track   (nxt_trk),
            .in_valid   (nxt_vld),
            .track_out  (cell_trk[g]),
            .valid_out  (cell_vld[g])
         );
      end
   endgenerate

   assign seek_dist = (head_ff >= cell_trk[0]) ? head_ff - cell_trk[0]
                                                : cell_trk[0] - head_ff;
   assign sum_wide = {1'b0, sum_ff} + (MB+1)'(best_dist_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      pos_in       = pos_ff;
      best_pos_in  = best_pos_ff;
      kill_pos_in  = kill_pos_ff;
      kill_en_in   = kill_en_ff;
      found_in     = found_ff;
      best_trk_in  = best_trk_ff;
      best_dist_in = best_dist_ff;
      head_in      = head_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_trk_in   = rsp_trk_ff;
      rsp_mov_in   = rsp_mov_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl         = '0;
      req_stall    = (state_ff != sstf_pkg::ST_IDLE);
      unique case (state_ff)
         sstf_pkg::ST_IDLE: begin
            if (do_load) begin
               count_in = count_ff + 1'b1;
            end
            if (accept && req_op == sstf_pkg::OP_RUN) begin
               head_in    = in_trk;
               sum_in     = '0;
               kill_en_in = 1'b0;
               pos_in     = '0;
               found_in   = 1'b0;
               remain_in  = count_ff;
               if (count_ff != '0) begin
                  state_in = sstf_pkg::ST_SCAN;
               end
            end
         end
         sstf_pkg::ST_SCAN: begin
            ctrl.shift = 1'b1;
            if (wrap_vld && (!found_ff || seek_dist < best_dist_ff ||
                (seek_dist == best_dist_ff && cell_trk[0] < best_trk_ff))) begin
               found_in     = 1'b1;
               best_pos_in  = pos_ff;
               best_trk_in  = cell_trk[0];
               best_dist_in = seek_dist;
            end
            if (pos_ff == PW'(MAX_REQUESTS - 1)) begin
               pos_in   = '0;
               state_in = sstf_pkg::ST_EMIT;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         sstf_pkg::ST_EMIT: begin
            if (out_free) begin
               sum_in       = sum_wide[MB] ? sstf_pkg::MOVE_MAX : sum_wide[MB-1:0];
               head_in      = best_trk_ff;
               kill_pos_in  = best_pos_ff;
               kill_en_in   = 1'b1;
               found_in     = 1'b0;
               remain_in    = remain_ff - 1'b1;
               rsp_valid_in = 1'b1;
               rsp_trk_in   = 12'(best_trk_ff);
               rsp_mov_in   = sum_wide[MB] ? sstf_pkg::MOVE_MAX : sum_wide[MB-1:0];
               rsp_last_in  = (remain_ff == CW'(1));
               if (remain_ff == CW'(1)) begin
                  ctrl.clear = 1'b1;
                  count_in   = '0;
                  state_in   = sstf_pkg::ST_IDLE;
               end else begin
                  state_in = sstf_pkg::ST_SCAN;
               end
            end
         end
         default: begin
            state_in = sstf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sstf_pkg::ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         pos_ff       <= '0;
         kill_en_ff   <= 1'b0;
         found_ff     <= 1'b0;
         head_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         pos_ff       <= pos_in;
         kill_en_ff   <= kill_en_in;
         found_ff     <= found_in;
         head_ff      <= head_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      best_pos_ff  <= best_pos_in;
      kill_pos_ff  <= kill_pos_in;
      best_trk_ff  <= best_trk_in;
      best_dist_ff <= best_dist_in;
      rsp_trk_ff   <= rsp_trk_in;
      rsp_mov_ff   <= rsp_mov_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_served_track   = rsp_trk_ff;
   assign rsp_total_movement = rsp_mov_ff;
   assign rsp_last           = rsp_last_ff;
endmodule
`default_nettype wire

### test/sstf_disk_scheduler_unit_test.sv
// Self-checking testbench for the shortest-seek-time-first disk scheduler.
// Needs sstf_pkg and sstf_disk_scheduler_unit; drives directed and random beats.
`timescale 1ns / 100ps
`default_nettype none
module sstf_disk_scheduler_unit_test;
   localparam int STORE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int HOLD_CYCLES = 1500;

   // One served request as the block reports it.
   typedef struct packed {
      logic [11:0] track;
      logic [17:0] movement;
      logic        last;
   } service_type;

   // One row of the directed table. check_typed asks that the prediction for
   // each result of the row's run be compared with the typed value as well.
   typedef struct {
      logic        op;
      logic [11:0] track;
      bit          check_typed;
      service_type typed;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_op = sstf_pkg::OP_LOAD;
   logic [11:0] req_track = '0;
   logic        rsp_stall = 1'b0;
   wire         req_stall;
   wire         rsp_valid;
   wire  [11:0] rsp_served_track;
   wire  [17:0] rsp_total_movement;
   wire         rsp_last;

   sstf_disk_scheduler_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_op(req_op), .req_track(req_track),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_served_track(rsp_served_track),
      .rsp_total_movement(rsp_total_movement),
      .rsp_last(rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: pending request tracks and the head after each run.
   logic [11:0] pending_tracks[$];
   logic [11:0] head_track;
   service_type expected_services[$];
   int          mismatch_count = 0;
   bit          stimulus_done = 0;
   bit          hold_off_now = 0;
   int          cycle_count = 0;

   // Work out the schedule caused by one accepted beat.
   task automatic schedule_beat(input logic op, input logic [11:0] trk);
      bit          taken[STORE_DEPTH];
      int          best_idx;
      int          best_dist;
      int          seek_dist;
      int          sum;
      service_type svc;
      if (op == sstf_pkg::OP_LOAD) begin
         if (pending_tracks.size() < STORE_DEPTH)
            pending_tracks.push_back(trk);
         return;
      end
      head_track = trk;
      sum = 0;
      foreach (taken[i]) taken[i] = 0;
      for (int n = 0; n < pending_tracks.size(); n++) begin
         best_idx = -1;
         best_dist = 0;
         for (int i = 0; i < pending_tracks.size(); i++) begin
            if (taken[i]) continue;
            seek_dist = (pending_tracks[i] >= head_track) ? pending_tracks[i] - head_track
                                                          : head_track - pending_tracks[i];
            if (best_idx < 0 || seek_dist < best_dist ||
                (seek_dist == best_dist &&
                 pending_tracks[i] < pending_tracks[best_idx])) begin
               best_idx = i;
               best_dist = seek_dist;
            end
         end
         taken[best_idx] = 1;
         head_track = pending_tracks[best_idx];
         sum = sum + best_dist;
         if (sum > int'(sstf_pkg::MOVE_MAX)) sum = int'(sstf_pkg::MOVE_MAX);
         svc.track = head_track;
         svc.movement = sum[17:0];
         svc.last = (n == pending_tracks.size() - 1);
         expected_services.push_back(svc);
      end
      pending_tracks.delete();
   endtask

   // Typed values for directed rows, matched against predictor output by order.
   service_type typed_services[$];
   bit          typed_flags[$];

   // Compare every accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      service_type got;
      service_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_served_track, rsp_total_movement, rsp_last};
         if (expected_services.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: track %0d move %0d last %0d",
                        got.track, got.movement, got.last);
         end else begin
            want = expected_services.pop_front();
            if (typed_flags.size() > 0) begin
               if (typed_flags.pop_front() && typed_services[0] !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("typed value differs from prediction: %p vs %p",
                              typed_services[0], want);
               end
               void'(typed_services.pop_front());
            end
            if (got.track !== want.track || got.movement !== want.movement ||
                got.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"result mismatch: expected track %0d move %0d last %0d,",
                            " got %0d %0d %0d"},
                           want.track, want.movement, want.last,
                           got.track, got.movement, got.last);
            end
         end
      end
   end

   // Receiver: random stalls, mostly short, a few long, plus a long hold-off
   // that this process counts out itself once the stimulus asks for it.
   initial begin
      int gap;
      @(negedge reset);
      while (1) begin
         @(posedge clock);
         if (hold_off_now) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off_now = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                               : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one beat and wait until it is accepted.
   task automatic send_beat(input logic op, input logic [11:0] trk);
      int gap;
      if ($urandom_range(0, 2) == 0) begin
         gap = ($urandom_range(0, 10) == 0) ? $urandom_range(8, 40)
                                            : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_track <= trk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      schedule_beat(op, trk);
   endtask

   // Let everything expected drain before changing phase.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_services.size() != 0) @(posedge clock);
   endtask

   stim_row_type directed[$];

   initial begin
      int n;
      int len;
      // Load of both extreme tracks, run from the middle: the upper track is
      // nearer (2047 against 2048), then movement 2047 + 4095.
      directed.push_back('{sstf_pkg::OP_LOAD, 12'd0, 0, '0});
      directed.push_back('{sstf_pkg::OP_LOAD, 12'd4095, 0, '0});
      directed.push_back('{sstf_pkg::OP_RUN, 12'd2048, 0, '0});
      // Run with an empty store emits nothing.
      directed.push_back('{sstf_pkg::OP_RUN, 12'd4095, 0, '0});
      // Equal tracks stored twice, and an exact tie around the head.
      directed.push_back('{sstf_pkg::OP_LOAD, 12'd100, 0, '0});
      directed.push_back('{sstf_pkg::OP_LOAD, 12'd300, 0, '0});
      directed.push_back('{sstf_pkg::OP_LOAD, 12'd300, 0, '0});
      directed.push_back('{sstf_pkg::OP_LOAD, 12'd200, 0, '0});
      directed.push_back('{sstf_pkg::OP_RUN, 12'd250, 0, '0});
      // Single request at the far extreme from head zero.
      directed.push_back('{sstf_pkg::OP_LOAD, 12'd4095, 0, '0});
      directed.push_back('{sstf_pkg::OP_RUN, 12'd0, 1, '{12'd4095, 18'd4095, 1'b1}});
      // Alternating bit patterns.
      directed.push_back('{sstf_pkg::OP_LOAD, 12'hAAA, 0, '0});
      directed.push_back('{sstf_pkg::OP_LOAD, 12'h555, 0, '0});
      directed.push_back('{sstf_pkg::OP_RUN, 12'hFFF, 0, '0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[r]) begin
         if (directed[r].op == sstf_pkg::OP_RUN) begin
            n = pending_tracks.size();
            for (int k = 0; k < n; k++) begin
               typed_flags.push_back(directed[r].check_typed);
               typed_services.push_back(directed[r].typed);
            end
         end
         send_beat(directed[r].op, directed[r].track);
      end
      drain_results();
      typed_flags.delete();
      typed_services.delete();

      // A full store of both extremes, and one more load that it drops.
      for (int k = 0; k < STORE_DEPTH; k++)
         send_beat(sstf_pkg::OP_LOAD, (k % 2) ? 12'd4095 : 12'd0);
      send_beat(sstf_pkg::OP_LOAD, 12'd1234);   // dropped, store is full
      send_beat(sstf_pkg::OP_RUN, 12'd2047);
      drain_results();
      // A full store of widely spread tracks on both sides of the head.
      for (int k = 0; k < STORE_DEPTH; k++)
         send_beat(sstf_pkg::OP_LOAD, (k % 2) ? 12'd4095 - 12'(k) : 12'(k * 30));
      send_beat(sstf_pkg::OP_RUN, 12'd2048);
      drain_results();

      // Pressure: receiver holds off while the sender keeps offering beats.
      hold_off_now = 1;
      for (int k = 0; k < 40; k++) send_beat(sstf_pkg::OP_LOAD, 12'($urandom));
      send_beat(sstf_pkg::OP_RUN, 12'($urandom));
      send_beat(sstf_pkg::OP_LOAD, 12'($urandom));
      send_beat(sstf_pkg::OP_RUN, 12'($urandom));
      drain_results();

      // Random part: well-formed load groups, mostly small, then a run.
      n = 0;
      while (n < 110) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70)
                                           : $urandom_range(0, 6);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 3) == 0)
               send_beat(sstf_pkg::OP_LOAD, 12'($urandom_range(0, 15)) + 12'd2040);
            else
               send_beat(sstf_pkg::OP_LOAD, 12'($urandom));
            n++;
         end
         send_beat(sstf_pkg::OP_RUN, 12'($urandom));
         n++;
      end
      req_valid <= 1'b0;
      stimulus_done = 1;
   end

   // End of run: drain, settle, report; or give up at the cycle limit.
   initial begin
      while (1) begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("** sstf_disk_scheduler_unit: FAILED **");
            $finish;
         end
         if (stimulus_done && expected_services.size() == 0) begin
            repeat (200) @(posedge clock);
            if (mismatch_count == 0 && expected_services.size() == 0)
               $display("** sstf_disk_scheduler_unit: PASSED **");
            else
               $display("** sstf_disk_scheduler_unit: FAILED **");
            $finish;
         end
      end
   end
endmodule
`default_nettype wire

### sim.f
hw/rtl/sstf_pkg.sv
hw/rtl/sstf_cell.sv
hw/rtl/sstf_disk_scheduler_unit.sv
test/sstf_disk_scheduler_unit_test.sv
